>>> rtl/swm_pkg.sv
// Shared widths, register map and word types for the sliding window maximum block.
package swm_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int POS_W      = 32;
  localparam int VAL_W      = 32;
  localparam int CFG_W      = 7;
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  localparam logic REG_WINDOW_SIZE = 1'b0;

  typedef struct packed {
    logic                    valid;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic                    load;
    logic                    shift;
    logic                    restart;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] sample;
  } step_t;

endpackage

>>> rtl/swm_if.sv
// Valid/ready channels for sample words and window maximum words.
interface swm_in_if import swm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] sample_value;
  logic                    restart;

  modport source (output valid, output sample_value, output restart, input ready);
  modport sink (input valid, input sample_value, input restart, output ready);
endinterface

interface swm_out_if import swm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [POS_W-1:0]        max_position;
  logic signed [VAL_W-1:0] max_value;

  modport source (output valid, output max_position, output max_value, input ready);
  modport sink (input valid, input max_position, input max_value, output ready);
endinterface

>>> rtl/swm_cell.sv
// One deque cell: holds a candidate and takes its neighbor's or the new sample.
module swm_cell import swm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  step_t  step,
  input  logic   front,
  input  logic   left_keep,
  input  logic   right_keep,
  input  entry_t right_entry,
  output entry_t entry,
  output entry_t entry_next,
  output logic   keep
);

  logic                    valid;
  logic [POS_W-1:0]        pos;
  logic signed [VAL_W-1:0] value;
  entry_t                  src;
  logic                    src_keep;
  logic                    prior_keep;

  assign entry = '{valid: valid, pos: pos, value: value};
  assign keep  = valid && !step.restart && !($signed(value) < $signed(step.sample));

  always_comb begin
    src        = step.shift ? right_entry : entry;
    src_keep   = step.shift ? right_keep : keep;
    prior_keep = step.shift ? (keep || front) : left_keep;
    entry_next = entry;
    if (step.load) begin
      priority if (src_keep) begin
        entry_next = src;
      end else if (prior_keep) begin
        entry_next = '{valid: 1'b1, pos: step.pos, value: step.sample};
      end else begin
        entry_next = src;
        entry_next.valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= entry_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    pos   <= entry_next.pos;
    value <= entry_next.value;
  end

endmodule

>>> rtl/sliding_window_max.sv
// Top level: sliding window maximum over a row of deque cells.
//
//   channel   dir  handshake        payload
//   samples   in   valid/ready      sample_value[31:0] signed, restart
//   maxima    out  valid/ready      max_position[31:0], max_value[31:0] signed
//   apb       in   psel/penable     paddr[2:0], pwdata/prdata[31:0], window_size at 0x0
//
// One sample per cycle unless stalled; its maximum word is registered on acceptance.
// All 64 cells compare against the sample in parallel and shift by at most one.
// Reset clears the cell valid bits, position, sample count and sets window_size to 1.
// A stalled maximum word holds the output register and stops sample intake.
module sliding_window_max import swm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  swm_in_if.sink            samples,
  swm_out_if.source         maxima,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CFG_W-1:0]        window_size;
  logic [POS_W-1:0]        next_position;
  logic [CNT_W-1:0]        seen;
  logic [CNT_W-1:0]        seen_next;
  logic [CNT_W-1:0]        win_eff;
  logic [POS_W-1:0]        pos_cur;
  logic [POS_W-1:0]        age;
  logic                    accept;
  logic                    drop;
  logic                    emit;
  logic                    out_valid;
  logic [POS_W-1:0]        out_position;
  logic signed [VAL_W-1:0] out_value;
  step_t                   step;
  entry_t                  entries [WINDOW_MAX];
  entry_t                  nexts [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]   keep;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? DATA_W'(window_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= CFG_W'(1);
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOW_SIZE) begin
      window_size <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    priority if (window_size == '0) begin
      win_eff = CNT_W'(1);
    end else if (CNT_W'(window_size) > CNT_W'(WINDOW_MAX)) begin
      win_eff = CNT_W'(WINDOW_MAX);
    end else begin
      win_eff = CNT_W'(window_size);
    end
  end

  assign samples.ready = !out_valid || maxima.ready;
  assign accept        = samples.valid && samples.ready;
  assign pos_cur       = samples.restart ? '0 : next_position;
  assign age           = pos_cur - entries[0].pos;
  assign drop          = entries[0].valid && !samples.restart && (age >= POS_W'(win_eff));

  always_comb begin
    step.load    = accept;
    step.shift   = drop || keep[WINDOW_MAX-1];
    step.restart = samples.restart;
    step.pos     = pos_cur;
    step.sample  = samples.sample_value;
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic   front;
    logic   left_keep;
    logic   right_keep;
    entry_t right_entry;

    if (i == 0) begin : g_front
      assign front     = 1'b1;
      assign left_keep = 1'b1;
    end else begin : g_inner_l
      assign front     = 1'b0;
      assign left_keep = keep[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_back
      assign right_keep  = 1'b0;
      assign right_entry = '{valid: 1'b0, pos: entries[i].pos, value: entries[i].value};
    end else begin : g_inner_r
      assign right_keep  = keep[i+1];
      assign right_entry = entries[i+1];
    end

    swm_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .step        (step),
      .front       (front),
      .left_keep   (left_keep),
      .right_keep  (right_keep),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .entry_next  (nexts[i]),
      .keep        (keep[i])
    );
  end

  always_comb begin
    priority if (samples.restart) begin
      seen_next = CNT_W'(1);
    end else if (seen < CNT_W'(WINDOW_MAX)) begin
      seen_next = seen + CNT_W'(1);
    end else begin
      seen_next = seen;
    end
  end

  assign emit = seen_next >= win_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      next_position <= '0;
      seen          <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        next_position <= pos_cur + POS_W'(1);
        seen          <= seen_next;
        out_valid     <= emit;
      end else if (maxima.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_position <= nexts[0].pos;
      out_value    <= nexts[0].value;
    end
  end

  assign maxima.valid        = out_valid;
  assign maxima.max_position = out_position;
  assign maxima.max_value    = out_value;

endmodule

>>> rtl/swm_checker.sv
// Port-level checks for the sliding window maximum block, bound to the top level.
module swm_checker import swm_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic signed [VAL_W-1:0] sample_value,
  input logic                    restart,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [POS_W-1:0]        max_position,
  input logic signed [VAL_W-1:0] max_value,
  input logic                    psel,
  input logic                    penable,
  input logic                    pwrite,
  input logic [ADDR_W-1:0]       paddr,
  input logic [DATA_W-1:0]       pwdata,
  input logic                    pready
);

  logic in_acc;
  logic win_le1;

  assign in_acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_le1 <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOW_SIZE) begin
      win_le1 <= (pwdata[CFG_W-1:0] <= CFG_W'(1));
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(max_position) && $stable(max_value))
    else $error("maximum word changed while stalled");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

  a_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid) |-> $past(in_acc))
    else $error("maximum word without a sample");

  a_first: assert property (@(posedge clk) disable iff (rst)
    in_acc && restart && win_le1 |=>
      out_valid && max_position == '0 && max_value == $past(sample_value))
    else $error("restart sample not reported at position zero");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("sample taken while maximum word stalled");

endmodule

bind sliding_window_max swm_checker u_swm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (samples.valid),
  .in_ready     (samples.ready),
  .sample_value (samples.sample_value),
  .restart      (samples.restart),
  .out_valid    (maxima.valid),
  .out_ready    (maxima.ready),
  .max_position (maxima.max_position),
  .max_value    (maxima.max_value),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .pready       (pready)
);

>>> sim/tb_sliding_window_max.sv
// Self-checking testbench for sliding_window_max: directed table, random phases, deque predictor.
module tb_sliding_window_max;
  import swm_pkg::*;

  typedef enum logic [0:0] {ROW_SAMPLE, ROW_WINDOW} row_kind_e;
  typedef enum {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_e;
  typedef enum {PAT_NOISE, PAT_TIES, PAT_FALL, PAT_RISE, PAT_EDGES} pattern_e;

  typedef struct packed {
    row_kind_e               kind;
    logic signed [VAL_W-1:0] value;
    logic                    restart;
    logic                    typed;
    logic                    has_max;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
  } row_t;

  typedef struct packed {
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
  } max_word_t;

  localparam logic [ADDR_W-1:0] WIN_ADDR = {REG_WINDOW_SIZE, 2'b00};
  localparam int LIMIT       = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int N_ROWS      = 28;
  localparam int N_PHASES    = 11;
  localparam int PHASE_ITEMS = 146;

  localparam row_t DIRECTED [N_ROWS] = '{
    '{ROW_SAMPLE, 32'h80000000, 1'b0, 1'b1, 1'b1, 32'd0, 32'h80000000},
    '{ROW_SAMPLE, 32'h7FFFFFFF, 1'b0, 1'b1, 1'b1, 32'd1, 32'h7FFFFFFF},
    '{ROW_SAMPLE, 32'h00000000, 1'b0, 1'b1, 1'b1, 32'd2, 32'h00000000},
    '{ROW_SAMPLE, 32'hFFFFFFFF, 1'b1, 1'b1, 1'b1, 32'd0, 32'hFFFFFFFF},
    '{ROW_SAMPLE, 32'h55555555, 1'b0, 1'b1, 1'b1, 32'd1, 32'h55555555},
    '{ROW_SAMPLE, 32'hAAAAAAAA, 1'b0, 1'b1, 1'b1, 32'd2, 32'hAAAAAAAA},
    '{ROW_WINDOW, 32'd0,        1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'd7,        1'b1, 1'b1, 1'b1, 32'd0, 32'd7},
    '{ROW_SAMPLE, 32'd7,        1'b0, 1'b1, 1'b1, 32'd1, 32'd7},
    '{ROW_WINDOW, 32'd3,        1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'd5,        1'b1, 1'b1, 1'b0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'd9,        1'b0, 1'b1, 1'b0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'd9,        1'b0, 1'b1, 1'b1, 32'd1, 32'd9},
    '{ROW_SAMPLE, 32'd9,        1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'd2,        1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'd1,        1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'hFFFFFFFC, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{ROW_WINDOW, 32'd6,        1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'd40,       1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'd30,       1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'd20,       1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'd10,       1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{ROW_WINDOW, 32'd2,        1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'd0,        1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'd0,        1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'd0,        1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{ROW_WINDOW, 32'd127,      1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{ROW_SAMPLE, 32'h7FFFFFFF, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0}
  };

  localparam logic [CFG_W-1:0] PHASE_WIN [N_PHASES] = '{
    7'd1, 7'd64, 7'd3, 7'd0, 7'd127, 7'd2, 7'd8, 7'd33, 7'd64, 7'd5, 7'd65
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  swm_in_if  samples();
  swm_out_if maxima();

  sliding_window_max dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .maxima  (maxima),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [POS_W-1:0]        keep_pos [WINDOW_MAX] = '{default: '0};
  logic signed [VAL_W-1:0] keep_val [WINDOW_MAX] = '{default: '0};
  int                      keep_cnt  = 0;
  int                      keep_head = 0;
  int                      warm_cnt  = 0;
  logic [POS_W-1:0]        run_pos   = '0;
  logic [CFG_W-1:0]        win_reg   = 7'd1;

  max_word_t maxima_due [$];
  max_word_t oldest;
  int err_count  = 0;
  int n_items    = 0;
  int n_restarts = 0;
  int n_maxima   = 0;
  int n_windows  = 0;
  int cycle_cnt  = 0;
  int tx_pct     = 0;
  int rx_pct     = 0;
  int hold_req   = 0;

  pattern_e                run_kind = PAT_NOISE;
  int                      run_left = 0;
  logic signed [VAL_W-1:0] run_val  = '0;

  function automatic bit step_window_max(input logic signed [VAL_W-1:0] s, input bit rs,
                                         output logic [POS_W-1:0] mp,
                                         output logic signed [VAL_W-1:0] mv);
    int w;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] age;
    w = int'(win_reg);
    if (w == 0) w = 1;
    if (w > WINDOW_MAX) w = WINDOW_MAX;
    if (rs) begin
      keep_cnt  = 0;
      keep_head = 0;
      run_pos   = '0;
      warm_cnt  = 0;
    end
    p = run_pos;
    age = p - keep_pos[keep_head];
    if (keep_cnt > 0 && age >= 32'(w)) begin
      keep_head = (keep_head + 1) % WINDOW_MAX;
      keep_cnt--;
    end
    while (keep_cnt > 0 && keep_val[(keep_head + keep_cnt - 1) % WINDOW_MAX] < s)
      keep_cnt--;
    if (keep_cnt >= WINDOW_MAX) begin
      keep_head = (keep_head + 1) % WINDOW_MAX;
      keep_cnt--;
    end
    keep_pos[(keep_head + keep_cnt) % WINDOW_MAX] = p;
    keep_val[(keep_head + keep_cnt) % WINDOW_MAX] = s;
    keep_cnt++;
    run_pos = p + 1;
    if (warm_cnt < WINDOW_MAX) warm_cnt++;
    mp = keep_pos[keep_head];
    mv = keep_val[keep_head];
    return warm_cnt >= w;
  endfunction

  function automatic logic signed [VAL_W-1:0] draw_sample();
    if (run_left == 0) begin
      run_kind = pattern_e'($urandom_range(4));
      run_left = $urandom_range(80, 1);
      run_val  = $urandom;
    end
    run_left--;
    case (run_kind)
      PAT_NOISE: return $urandom;
      PAT_TIES:  return int'($urandom_range(6)) - 3;
      PAT_FALL: begin
        run_val = run_val - int'($urandom_range(3));
        return run_val;
      end
      PAT_RISE: begin
        run_val = run_val + int'($urandom_range(3));
        return run_val;
      end
      default:   return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
    endcase
  endfunction

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  task automatic send_sample(input logic signed [VAL_W-1:0] s, input bit rs, input bit typed,
                             input bit has_max, input logic [POS_W-1:0] tp,
                             input logic signed [VAL_W-1:0] tv);
    logic [POS_W-1:0]        mp;
    logic signed [VAL_W-1:0] mv;
    bit                      got;
    while (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid        <= 1'b1;
    samples.sample_value <= s;
    samples.restart      <= rs;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    got = step_window_max(s, rs, mp, mv);
    if (typed) begin
      got = has_max;
      mp  = tp;
      mv  = tv;
    end
    if (got) maxima_due.insert(maxima_due.size(), '{mp, mv});
    n_items++;
    if (rs) n_restarts++;
  endtask

  task automatic go_idle();
    samples.valid <= 1'b0;
    while (maxima_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    win_reg = data[CFG_W-1:0];
    n_windows++;
  endtask

  initial begin : maxima_sink
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    maxima.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
        maxima.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        maxima.ready <= 1'b0;
      end else begin
        maxima.ready <= (rx_pct == 0) || ($urandom_range(99) >= rx_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && maxima.valid && maxima.ready) begin
      n_maxima++;
      if (maxima_due.size() == 0) begin
        note_error($sformatf("unexpected max word: pos %0d value %0d",
                             maxima.max_position, maxima.max_value));
      end else begin
        oldest = maxima_due[0];
        maxima_due.delete(0);
        if (maxima.max_position !== oldest.pos || maxima.max_value !== oldest.val)
          note_error($sformatf("max word mismatch: expected pos %0d value %0d, got pos %0d value %0d",
                               oldest.pos, oldest.val, maxima.max_position, maxima.max_value));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("sliding_window_max test failed");
      $finish;
    end
  end

  initial begin
    bit         rs;
    int         restart_pct;
    idle_mode_e mode;
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    samples.valid        = 1'b0;
    samples.sample_value = '0;
    samples.restart      = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_WINDOW) begin
        go_idle();
        apb_write(WIN_ADDR, DATA_W'(DIRECTED[i].value[CFG_W-1:0]));
      end else begin
        send_sample(DIRECTED[i].value, DIRECTED[i].restart, DIRECTED[i].typed,
                    DIRECTED[i].has_max, DIRECTED[i].pos, DIRECTED[i].val);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      go_idle();
      apb_write(WIN_ADDR, DATA_W'(PHASE_WIN[ph]));
      mode = idle_mode_e'(ph % 4);
      case (mode)
        IDLE_NONE: begin tx_pct = 0;  rx_pct = 0;  end
        IDLE_TX:   begin tx_pct = 63; rx_pct = 0;  end
        IDLE_RX:   begin tx_pct = 0;  rx_pct = 63; end
        default:   begin tx_pct = 27; rx_pct = 27; end
      endcase
      restart_pct = (PHASE_WIN[ph] > 16) ? 1 : 5;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (mode == IDLE_NONE && ph != 0 && k == 30) hold_req++;
        rs = $urandom_range(99) < restart_pct;
        send_sample(draw_sample(), rs, 1'b0, 1'b0, '0, '0);
      end
    end

    samples.valid <= 1'b0;
    while (maxima_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d sample words (%0d restarts) and %0d max words", n_items, n_restarts,
             n_maxima);
    $display("across %0d window settings, idle and stall mixes, and long output holds",
             n_windows);
    if (err_count == 0) begin
      $display("sliding_window_max test passed");
    end else begin
      $display("%0d errors", err_count);
      $display("sliding_window_max test failed");
    end
    $finish;
  end

endmodule
